/* hdl/svcr_pkg.sv */
// Shared constants, codes and control types of the cubic resampling voice.
package svcr_pkg;

  // Field and datapath widths.
  localparam int SAMPLE_W    = 16;
  localparam int MIX_W       = 24;
  localparam int FRAC_W      = 16;
  localparam int FRAME_W     = 16;
  localparam int FIELD_W     = 17;
  localparam int ADDR_W      = 17;
  localparam int STORE_DEPTH = 131072;
  localparam int RATE_W      = 19;
  localparam int GAIN_W      = 16;
  localparam int EPOCH_W     = 32;
  localparam int POS_W       = 34;
  localparam int STEP_W      = 24;
  localparam int ACC_W       = 22;
  localparam int DIV_W       = 35;
  localparam int SCL_W       = 31;
  localparam int SUM_W       = 32;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  // Right shift that maps a gained twice-value onto the mix bus.
  localparam int GAIN_SHIFT  = 15 + SAMPLE_W - MIX_W + 1;

  localparam logic [FIELD_W-1:0] MAX_FRAMES   = 17'h10000;
  localparam logic [RATE_W-1:0]  DEFAULT_RATE = 19'd48000;
  localparam logic [GAIN_W-1:0]  UNITY_GAIN   = 16'h8000;
  localparam logic [22:0]        STEP_MAX     = 23'h7FFFFF;

  // Register map, decoded on address bit 2.
  localparam logic REG_OUTPUT_RATE = 1'b0;
  localparam logic REG_GAIN        = 1'b1;

  typedef enum logic [1:0] {
    OP_RENDER = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2,
    OP_LOAD   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_DIV,
    S_READ,
    S_COEF,
    S_HORN,
    S_SCALE,
    S_MIX
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       load;
    logic       start;
    logic       stop;
    logic       set_step;
    logic       halt;
    logic       enter;
    logic       rd_en;
    logic [1:0] tap;
    logic       cap_en;
    logic [1:0] cap_tap;
    logic       coef;
    logic       horn;
    logic [1:0] horn_sel;
    logic       scale;
    logic       mix;
    logic       ch;
    logic       advance;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic playing;
    logic in_slice;
    logic stereo;
    logic div_busy;
  } sts_t;

endpackage

/* hdl/svcr_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module svcr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/svcr_ctrl.sv */
// Controller: sequences load, start, stop and render items over the datapath.
module svcr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output svcr_pkg::cmd_t cmd,
  input  svcr_pkg::sts_t sts
);
  import svcr_pkg::*;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] hcnt_r, hcnt_nxt;
  logic       ch_r, ch_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      hcnt_r      <= '0;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hcnt_r      <= hcnt_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    logic finish;
    finish        = 1'b0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    hcnt_nxt      = hcnt_r;
    ch_nxt        = ch_r;
    cmd           = '0;
    cmd.tap       = cnt_r[1:0];
    cmd.cap_tap   = 2'(cnt_r - 3'd1);
    cmd.horn_sel  = hcnt_r;
    cmd.ch        = ch_r;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        in_stall = out_valid_r && out_stall;
        if (in_valid && !in_stall) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_LOAD: begin
            cmd.load = 1'b1;
            finish   = 1'b1;
          end
          OP_STOP: begin
            cmd.stop = 1'b1;
            finish   = 1'b1;
          end
          OP_START: begin
            cmd.start = 1'b1;
            state_nxt = S_DIV;
          end
          default: begin
            if (!sts.playing) begin
              finish = 1'b1;
            end else if (!sts.in_slice) begin
              cmd.halt = 1'b1;
              finish   = 1'b1;
            end else begin
              cmd.enter = 1'b1;
              ch_nxt    = 1'b0;
              cnt_nxt   = '0;
              state_nxt = S_READ;
            end
          end
        endcase
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          cmd.set_step = 1'b1;
          finish       = 1'b1;
        end
      end
      // Issue four tap reads; each word is captured in the cycle after its read.
      S_READ: begin
        cmd.rd_en  = (cnt_r < 3'd4);
        cmd.cap_en = (cnt_r != 3'd0);
        cnt_nxt    = cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          state_nxt = S_COEF;
        end
      end
      S_COEF: begin
        cmd.coef  = 1'b1;
        hcnt_nxt  = '0;
        state_nxt = S_HORN;
      end
      S_HORN: begin
        cmd.horn = 1'b1;
        hcnt_nxt = hcnt_r + 2'd1;
        if (hcnt_r == 2'd2) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_MIX;
      end
      S_MIX: begin
        cmd.mix = 1'b1;
        if (sts.stereo && !ch_r) begin
          ch_nxt    = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_READ;
        end else begin
          cmd.advance = 1'b1;
          finish      = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      out_valid_nxt = 1'b1;
      state_nxt     = S_IDLE;
    end
  end

endmodule

/* hdl/svcr_dp.sv */
// Datapath: voice state, sample store, step divider and cubic interpolator.
module svcr_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  svcr_pkg::cmd_t                         cmd,
  output svcr_pkg::sts_t                         sts,
  input  logic                                   cfg_we,
  input  logic                                   cfg_sel,
  input  logic [svcr_pkg::PDATA_W-1:0]           cfg_wdata,
  output logic [svcr_pkg::PDATA_W-1:0]           cfg_rdata,
  input  logic [1:0]                             in_operation,
  input  logic signed [svcr_pkg::MIX_W-1:0]      in_mix_left_in,
  input  logic signed [svcr_pkg::MIX_W-1:0]      in_mix_right_in,
  input  logic [svcr_pkg::FIELD_W-1:0]           in_start_frame,
  input  logic [svcr_pkg::FIELD_W-1:0]           in_end_frame,
  input  logic                                   in_reverse,
  input  logic [svcr_pkg::EPOCH_W-1:0]           in_epoch,
  input  logic [svcr_pkg::RATE_W-1:0]            in_source_rate,
  input  logic [1:0]                             in_channel_count,
  input  logic [svcr_pkg::FIELD_W-1:0]           in_asset_frames,
  input  logic [svcr_pkg::ADDR_W-1:0]            in_sample_address,
  input  logic signed [svcr_pkg::SAMPLE_W-1:0]   in_sample_value,
  output logic signed [svcr_pkg::MIX_W-1:0]      out_mix_left_out,
  output logic signed [svcr_pkg::MIX_W-1:0]      out_mix_right_out,
  output logic                                   out_active,
  output logic [svcr_pkg::FRAME_W-1:0]           out_source_frame,
  output logic [svcr_pkg::EPOCH_W-1:0]           out_acknowledged_epoch
);
  import svcr_pkg::*;

  // Captured item fields.
  op_t                        op_r;
  logic [FIELD_W-1:0]         sf_r, ef_r, frames_r;
  logic                       rev_r, stereo_in_r;
  logic [EPOCH_W-1:0]         epoch_r;
  logic [RATE_W-1:0]          src_r;
  logic [ADDR_W-1:0]          addr_r;
  logic signed [SAMPLE_W-1:0] val_r;
  logic signed [MIX_W-1:0]    res_l_r, res_r_r;

  // Voice state.
  logic signed [POS_W-1:0]    pos_r;
  logic signed [STEP_W-1:0]   step_r;
  logic [FIELD_W-1:0]         first_r, pe_r;
  logic                       stereo_r, playing_r;
  logic [FRAME_W-1:0]         reported_r;
  logic [EPOCH_W-1:0]         ack_r;
  logic [RATE_W-1:0]          rate_r;
  logic [GAIN_W-1:0]          gain_r;

  // Divider.
  logic                       div_busy_r;
  logic [5:0]                 div_cnt_r;
  logic [DIV_W-1:0]           div_q_r;
  logic [RATE_W-1:0]          div_rem_r, div_den_r;

  // Interpolator.
  logic [FRAME_W-1:0]         base_r, frac_r;
  logic signed [SAMPLE_W-1:0] y_r [4];
  logic signed [ACC_W-1:0]    k0_r, k1_r, k2_r, acc_r;
  logic signed [SCL_W-1:0]    scaled_r;
  logic [SAMPLE_W-1:0]        rd_data;

  assign out_mix_left_out       = res_l_r;
  assign out_mix_right_out      = res_r_r;
  assign out_active             = playing_r;
  assign out_source_frame       = reported_r;
  assign out_acknowledged_epoch = ack_r;

  // Register readback.
  assign cfg_rdata = (cfg_sel == REG_GAIN) ? PDATA_W'(gain_r) : PDATA_W'(rate_r);

  // Start: clamp the slice to the asset and pick the first frame.
  logic [FIELD_W-1:0] frames_c, first_c, pe_c, startf_c;
  logic               nonempty_c;
  always_comb begin
    frames_c   = (frames_r > MAX_FRAMES) ? MAX_FRAMES : frames_r;
    first_c    = (sf_r < frames_c) ? sf_r : frames_c;
    pe_c       = (ef_r < frames_c) ? ef_r : frames_c;
    nonempty_c = (pe_c > first_c);
    startf_c   = (rev_r && nonempty_c) ? (pe_c - 17'd1) : first_c;
  end

  // Step from the finished quotient, saturated and signed by direction.
  // A source rate of zero plays at a step of exactly one frame.
  logic [22:0]             st_c;
  logic signed [STEP_W-1:0] step_c;
  always_comb begin
    if (src_r == '0) begin
      st_c = 23'd1 << FRAC_W;
    end else begin
      st_c = (|div_q_r[DIV_W-1:23]) ? STEP_MAX : div_q_r[22:0];
    end
    step_c = rev_r ? -$signed({1'b0, st_c}) : $signed({1'b0, st_c});
  end

  // One restoring division step.
  logic [RATE_W:0]   rem_sh;
  logic              rem_ge;
  logic [RATE_W-1:0] rem_nxt;
  always_comb begin
    rem_sh  = {div_rem_r, div_q_r[DIV_W-1]};
    rem_ge  = (rem_sh >= {1'b0, div_den_r});
    rem_nxt = rem_ge ? RATE_W'(rem_sh - {1'b0, div_den_r}) : rem_sh[RATE_W-1:0];
  end

  // Slice test on the current position.
  logic signed [POS_W-1:0] lo_c, hi_c;
  assign lo_c = $signed({1'b0, first_r, {FRAC_W{1'b0}}});
  assign hi_c = $signed({1'b0, pe_r, {FRAC_W{1'b0}}});

  assign sts.op       = op_r;
  assign sts.playing  = playing_r;
  assign sts.in_slice = (pos_r >= lo_c) && (pos_r < hi_c);
  assign sts.stereo   = stereo_r;
  assign sts.div_busy = div_busy_r;

  // Tap frame clamped into the slice, then the interleaved address.
  logic signed [FIELD_W:0] fr_c, lo_f, hi_f, fcl_c;
  logic [ADDR_W-1:0]       raddr_c;
  always_comb begin
    fr_c  = $signed({2'b00, base_r}) + $signed({{(FIELD_W-1){1'b0}}, cmd.tap}) - 18'sd1;
    lo_f  = $signed({1'b0, first_r});
    hi_f  = $signed({1'b0, pe_r}) - 18'sd1;
    fcl_c = fr_c;
    if (fcl_c < lo_f) begin
      fcl_c = lo_f;
    end
    if (fcl_c > hi_f) begin
      fcl_c = hi_f;
    end
    raddr_c = stereo_r ? {fcl_c[FRAME_W-1:0], cmd.ch} : {1'b0, fcl_c[FRAME_W-1:0]};
  end

  svcr_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.load),
    .waddr(addr_r),
    .wdata(val_r),
    .re   (cmd.rd_en),
    .raddr(raddr_c),
    .rdata(rd_data)
  );

  // Catmull-Rom coefficients, doubled.
  logic signed [ACC_W-1:0] e0, e1, e2, e3, k0_c, k1_c, k2_c, k3_c;
  always_comb begin
    e0   = ACC_W'(y_r[0]);
    e1   = ACC_W'(y_r[1]);
    e2   = ACC_W'(y_r[2]);
    e3   = ACC_W'(y_r[3]);
    k0_c = e1 <<< 1;
    k1_c = e2 - e0;
    k2_c = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
    k3_c = (e3 - e0) + ((e1 - e2) <<< 1) + (e1 - e2);
  end

  // Horner step: one multiply by the fraction, floor, add coefficient.
  logic signed [ACC_W+FRAC_W:0] hprod;
  logic signed [ACC_W+FRAC_W:0] hsh;
  logic signed [ACC_W-1:0]      kk_c, horn_c;
  always_comb begin
    hprod = acc_r * $signed({1'b0, frac_r});
    hsh   = hprod >>> FRAC_W;
    case (cmd.horn_sel)
      2'd0:    kk_c = k2_r;
      2'd1:    kk_c = k1_r;
      default: kk_c = k0_r;
    endcase
    horn_c = hsh[ACC_W-1:0] + kk_c;
  end

  // Gain scaling onto the mix bus.
  logic signed [ACC_W+GAIN_W:0] gprod;
  logic signed [ACC_W+GAIN_W:0] gsh;
  always_comb begin
    gprod = acc_r * $signed({1'b0, gain_r});
    gsh   = gprod >>> GAIN_SHIFT;
  end

  function automatic logic signed [MIX_W-1:0] sat_add(
    input logic signed [MIX_W-1:0] a,
    input logic signed [SCL_W-1:0] b
  );
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    s  = SUM_W'(a) + SUM_W'(b);
    hi = (SUM_W'(1) <<< (MIX_W - 1)) - SUM_W'(1);
    lo = -hi - SUM_W'(1);
    if (s > hi) begin
      return hi[MIX_W-1:0];
    end else if (s < lo) begin
      return lo[MIX_W-1:0];
    end
    return s[MIX_W-1:0];
  endfunction

  // Item capture and work registers without reset.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r        <= op_t'(in_operation);
      sf_r        <= in_start_frame;
      ef_r        <= in_end_frame;
      frames_r    <= in_asset_frames;
      rev_r       <= in_reverse;
      stereo_in_r <= in_channel_count[1];
      epoch_r     <= in_epoch;
      src_r       <= in_source_rate;
      addr_r      <= in_sample_address;
      val_r       <= in_sample_value;
      res_l_r     <= in_mix_left_in;
      res_r_r     <= in_mix_right_in;
    end
    if (cmd.mix) begin
      if (!cmd.ch) begin
        res_l_r <= sat_add(res_l_r, scaled_r);
      end
      if (cmd.ch || !stereo_r) begin
        res_r_r <= sat_add(res_r_r, scaled_r);
      end
    end
    if (cmd.enter) begin
      base_r <= pos_r[FRAC_W+FRAME_W-1:FRAC_W];
      frac_r <= pos_r[FRAC_W-1:0];
    end
    if (cmd.cap_en) begin
      y_r[cmd.cap_tap] <= rd_data;
    end
    if (cmd.coef) begin
      k0_r  <= k0_c;
      k1_r  <= k1_c;
      k2_r  <= k2_c;
      acc_r <= k3_c;
    end else if (cmd.horn) begin
      acc_r <= horn_c;
    end
    if (cmd.scale) begin
      scaled_r <= gsh[SCL_W-1:0];
    end
    if (cmd.start) begin
      div_den_r <= (rate_r == '0) ? DEFAULT_RATE : rate_r;
    end
  end

  // Divider control and datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
    end else if (cmd.start) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= 6'(DIV_W);
    end else if (div_busy_r) begin
      div_cnt_r <= div_cnt_r - 6'd1;
      if (div_cnt_r == 6'd1) begin
        div_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      div_q_r   <= {src_r, {FRAC_W{1'b0}}};
      div_rem_r <= '0;
    end else if (div_busy_r) begin
      div_q_r   <= {div_q_r[DIV_W-2:0], rem_ge};
      div_rem_r <= rem_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= DEFAULT_RATE;
      gain_r <= UNITY_GAIN;
    end else if (cfg_we) begin
      if (cfg_sel == REG_OUTPUT_RATE) begin
        rate_r <= cfg_wdata[RATE_W-1:0];
      end else begin
        gain_r <= (cfg_wdata[GAIN_W-1:0] > UNITY_GAIN) ? UNITY_GAIN : cfg_wdata[GAIN_W-1:0];
      end
    end
  end

  // Voice state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      step_r     <= '0;
      first_r    <= '0;
      pe_r       <= '0;
      stereo_r   <= 1'b0;
      playing_r  <= 1'b0;
      reported_r <= '0;
      ack_r      <= '0;
    end else begin
      if (cmd.start) begin
        first_r    <= first_c;
        pe_r       <= pe_c;
        stereo_r   <= stereo_in_r;
        pos_r      <= $signed({1'b0, startf_c, {FRAC_W{1'b0}}});
        reported_r <= startf_c[FRAME_W-1:0];
        playing_r  <= nonempty_c;
        ack_r      <= epoch_r;
      end
      if (cmd.set_step) begin
        step_r <= step_c;
      end
      if (cmd.stop) begin
        pos_r      <= '0;
        first_r    <= '0;
        pe_r       <= '0;
        reported_r <= '0;
        playing_r  <= 1'b0;
        ack_r      <= epoch_r;
      end
      if (cmd.halt) begin
        playing_r <= 1'b0;
      end
      if (cmd.advance) begin
        reported_r <= base_r;
        pos_r      <= pos_r + POS_W'(step_r);
      end
    end
  end

endmodule

/* hdl/sample_voice_cubic_resampler_core.sv */
// Top level of the one-voice cubic resampling sample player.
//
// Input items arrive on in_valid/in_stall and each yields exactly one result
// transfer on out_valid/out_stall. Operation codes: render, start, stop, load.
// A load writes one word of the 128K-word sample store. A start runs the
// one-bit-per-cycle divider that forms the playback step from the source
// and output rates. A render of a playing voice reads four taps per
// channel from the single store read port and runs three Horner steps and
// a gain multiply per channel; a render of an idle voice, or one that
// leaves the slice, finishes without them.
// The output fields sit in registers and hold while out_stall is high; the
// next item is accepted in the cycle its predecessor's result is taken.
// Configuration is an APB-style port: output_rate at byte 0, gain at byte 4.
// Reset (rst_n low, synchronous) stops the voice, clears position, slice,
// step and tags, and restores output_rate 48000 and unity gain. The sample
// store is not cleared and must be loaded before it is played.
module sample_voice_cubic_resampler_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [svcr_pkg::PADDR_W-1:0]         paddr,
  input  logic [svcr_pkg::PDATA_W-1:0]         pwdata,
  output logic [svcr_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_operation,
  input  logic signed [svcr_pkg::MIX_W-1:0]    in_mix_left_in,
  input  logic signed [svcr_pkg::MIX_W-1:0]    in_mix_right_in,
  input  logic [svcr_pkg::FIELD_W-1:0]         in_start_frame,
  input  logic [svcr_pkg::FIELD_W-1:0]         in_end_frame,
  input  logic                                 in_reverse,
  input  logic [svcr_pkg::EPOCH_W-1:0]         in_epoch,
  input  logic [svcr_pkg::RATE_W-1:0]          in_source_rate,
  input  logic [1:0]                           in_channel_count,
  input  logic [svcr_pkg::FIELD_W-1:0]         in_asset_frames,
  input  logic [svcr_pkg::ADDR_W-1:0]          in_sample_address,
  input  logic signed [svcr_pkg::SAMPLE_W-1:0] in_sample_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [svcr_pkg::MIX_W-1:0]    out_mix_left_out,
  output logic signed [svcr_pkg::MIX_W-1:0]    out_mix_right_out,
  output logic                                 out_active,
  output logic [svcr_pkg::FRAME_W-1:0]         out_source_frame,
  output logic [svcr_pkg::EPOCH_W-1:0]         out_acknowledged_epoch
);
  import svcr_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  // Register write strobe; pready is held high, so accesses never wait.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  svcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  svcr_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_we),
    .cfg_sel               (paddr[2]),
    .cfg_wdata             (pwdata),
    .cfg_rdata             (prdata),
    .in_operation          (in_operation),
    .in_mix_left_in        (in_mix_left_in),
    .in_mix_right_in       (in_mix_right_in),
    .in_start_frame        (in_start_frame),
    .in_end_frame          (in_end_frame),
    .in_reverse            (in_reverse),
    .in_epoch              (in_epoch),
    .in_source_rate        (in_source_rate),
    .in_channel_count      (in_channel_count),
    .in_asset_frames       (in_asset_frames),
    .in_sample_address     (in_sample_address),
    .in_sample_value       (in_sample_value),
    .out_mix_left_out      (out_mix_left_out),
    .out_mix_right_out     (out_mix_right_out),
    .out_active            (out_active),
    .out_source_frame      (out_source_frame),
    .out_acknowledged_epoch(out_acknowledged_epoch)
  );

  // A held result blocks new input transfers.
  a_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input accepted while a result is held");

  // No result is presented in the cycle after an input transfer.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("result appeared right after input transfer");

  // Starting a slice always launches the step divider.
  a_start_divides: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> sts.div_busy)
    else $error("divider did not start");

endmodule

/* bench/sample_voice_cubic_resampler_checker.sv */
// Checker for the cubic resampling voice: predicts every result and compares it.
module sample_voice_cubic_resampler_checker
  import svcr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  input  logic                       pready,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [1:0]                 in_operation,
  input  logic signed [MIX_W-1:0]    in_mix_left_in,
  input  logic signed [MIX_W-1:0]    in_mix_right_in,
  input  logic [FIELD_W-1:0]         in_start_frame,
  input  logic [FIELD_W-1:0]         in_end_frame,
  input  logic                       in_reverse,
  input  logic [EPOCH_W-1:0]         in_epoch,
  input  logic [RATE_W-1:0]          in_source_rate,
  input  logic [1:0]                 in_channel_count,
  input  logic [FIELD_W-1:0]         in_asset_frames,
  input  logic [ADDR_W-1:0]          in_sample_address,
  input  logic signed [SAMPLE_W-1:0] in_sample_value,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [MIX_W-1:0]    out_mix_left_out,
  input  logic signed [MIX_W-1:0]    out_mix_right_out,
  input  logic                       out_active,
  input  logic [FRAME_W-1:0]         out_source_frame,
  input  logic [EPOCH_W-1:0]         out_acknowledged_epoch,
  output int                         mismatches,
  output int                         pending
);

  typedef struct {
    logic signed [MIX_W-1:0] left;
    logic signed [MIX_W-1:0] right;
    logic                    active;
    logic [FRAME_W-1:0]      frame;
    logic [EPOCH_W-1:0]      epoch;
  } frame_result_t;

  frame_result_t expected_frames[$];

  // Shadow copy of the voice state and the registers.
  shortint            voice_mem [STORE_DEPTH];
  longint             position;
  longint             step;
  longint             slice_lo;
  longint             slice_hi;
  bit                 stereo;
  bit                 playing;
  logic [FRAME_W-1:0] shown_frame;
  logic [EPOCH_W-1:0] ack_epoch;
  longint             rate_hz;
  longint             gain_q15;

  initial begin
    mismatches = 0;
    pending = 0;
  end

  // One tap, with the frame clamped inside the slice.
  function automatic longint fetch_tap(longint frame, int ch);
    longint f;
    longint idx;
    f = frame;
    if (f < slice_lo) f = slice_lo;
    if (f > slice_hi - 1) f = slice_hi - 1;
    idx = stereo ? f * 2 + ch : f;
    if (idx < 0 || idx >= STORE_DEPTH) return 0;
    return longint'(voice_mem[idx]);
  endfunction

  // Catmull-Rom value times two, evaluated by Horner steps with floor shifts.
  function automatic longint catmull_twice(longint base, longint frac, int ch);
    longint y0, y1, y2, y3, k0, k1, k2, k3, acc;
    y0 = fetch_tap(base - 1, ch);
    y1 = fetch_tap(base, ch);
    y2 = fetch_tap(base + 1, ch);
    y3 = fetch_tap(base + 2, ch);
    k0 = 2 * y1;
    k1 = y2 - y0;
    k2 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
    k3 = (y3 - y0) + 3 * (y1 - y2);
    acc = k3;
    acc = ((acc * frac) >>> FRAC_W) + k2;
    acc = ((acc * frac) >>> FRAC_W) + k1;
    acc = ((acc * frac) >>> FRAC_W) + k0;
    return acc;
  endfunction

  // Gain the voice sample onto the mix bus and add with saturation.
  function automatic logic signed [MIX_W-1:0] mix_in(longint bus, longint twice);
    longint sum;
    longint top;
    top = (longint'(1) <<< (MIX_W - 1)) - 1;
    sum = bus + ((twice * gain_q15) >>> GAIN_SHIFT);
    if (sum > top) sum = top;
    if (sum < -top - 1) sum = -top - 1;
    return sum[MIX_W-1:0];
  endfunction

  task automatic predict_item(output frame_result_t res);
    longint frames, s, e, startf, q, st, one, base, frac, vl, vr, rate;
    res.left = in_mix_left_in;
    res.right = in_mix_right_in;
    one = longint'(1) <<< FRAC_W;
    case (op_t'(in_operation))
      OP_START: begin
        frames = in_asset_frames;
        if (frames > MAX_FRAMES) frames = MAX_FRAMES;
        s = in_start_frame;
        e = in_end_frame;
        slice_lo = s < frames ? s : frames;
        slice_hi = e < frames ? e : frames;
        stereo = in_channel_count >= 2;
        startf = (in_reverse && slice_hi > slice_lo) ? slice_hi - 1 : slice_lo;
        position = startf * one;
        rate = rate_hz != 0 ? rate_hz : longint'(DEFAULT_RATE);
        if (in_source_rate == 0) begin
          st = one;
        end else begin
          q = (longint'(in_source_rate) <<< FRAC_W) / rate;
          st = q > longint'(STEP_MAX) ? longint'(STEP_MAX) : q;
        end
        step = in_reverse ? -st : st;
        shown_frame = startf[FRAME_W-1:0];
        playing = slice_hi > slice_lo;
        ack_epoch = in_epoch;
      end
      OP_STOP: begin
        position = 0;
        slice_lo = 0;
        slice_hi = 0;
        shown_frame = '0;
        playing = 0;
        ack_epoch = in_epoch;
      end
      OP_LOAD: begin
        voice_mem[in_sample_address] = in_sample_value;
      end
      default: begin
        if (playing) begin
          if (position < slice_lo * one || position >= slice_hi * one) begin
            playing = 0;
          end else begin
            base = position >>> FRAC_W;
            frac = position & (one - 1);
            vl = catmull_twice(base, frac, 0);
            vr = stereo ? catmull_twice(base, frac, 1) : vl;
            shown_frame = base[FRAME_W-1:0];
            res.left = mix_in(in_mix_left_in, vl);
            res.right = mix_in(in_mix_right_in, vr);
            position += step;
          end
        end
      end
    endcase
    res.active = playing;
    res.frame = shown_frame;
    res.epoch = ack_epoch;
  endtask

  task automatic flag_mismatch(string field, longint got, longint want);
    $display("mismatch on %s: got %0d, want %0d", field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    frame_result_t next;
    if (!rst_n) begin
      expected_frames.delete();
      position = 0;
      step = 0;
      slice_lo = 0;
      slice_hi = 0;
      stereo = 0;
      playing = 0;
      shown_frame = '0;
      ack_epoch = '0;
      rate_hz = DEFAULT_RATE;
      gain_q15 = UNITY_GAIN;
    end else begin
      // Result transfer: compare against the oldest prediction.
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          flag_mismatch("unexpected result transfer", 1, 0);
        end else begin
          want = expected_frames.pop_front();
          if (out_mix_left_out !== want.left)
            flag_mismatch("mix_left_out", out_mix_left_out, want.left);
          if (out_mix_right_out !== want.right)
            flag_mismatch("mix_right_out", out_mix_right_out, want.right);
          if (out_active !== want.active)
            flag_mismatch("active", out_active, want.active);
          if (out_source_frame !== want.frame)
            flag_mismatch("source_frame", out_source_frame, want.frame);
          if (out_acknowledged_epoch !== want.epoch)
            flag_mismatch("acknowledged_epoch", out_acknowledged_epoch, want.epoch);
        end
      end
      // Input transfer: advance the shadow voice.
      if (in_valid && !in_stall) begin
        predict_item(next);
        expected_frames.push_back(next);
      end
      // Register write.
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_GAIN)
          gain_q15 = pwdata[15:0] > UNITY_GAIN ? UNITY_GAIN : pwdata[15:0];
        else
          rate_hz = pwdata[RATE_W-1:0];
      end
    end
    pending <= expected_frames.size();
  end

endmodule

/* bench/sample_voice_cubic_resampler_core_tb.sv */
// Testbench top of the cubic resampling voice: stimulus, flow control and verdict.
module sample_voice_cubic_resampler_core_tb;
  import svcr_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 250;

  typedef struct {
    op_t                       op;
    logic signed [MIX_W-1:0]   ml;
    logic signed [MIX_W-1:0]   mr;
    logic [FIELD_W-1:0]        sf;
    logic [FIELD_W-1:0]        ef;
    logic                      rev;
    logic [EPOCH_W-1:0]        ep;
    logic [RATE_W-1:0]         src;
    logic [1:0]                cc;
    logic [FIELD_W-1:0]        af;
    logic [ADDR_W-1:0]         addr;
    logic signed [SAMPLE_W-1:0] val;
  } voice_cmd_t;

  logic clk = 0;
  logic rst_n = 0;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_operation = '0;
  logic signed [MIX_W-1:0] in_mix_left_in = '0;
  logic signed [MIX_W-1:0] in_mix_right_in = '0;
  logic [FIELD_W-1:0] in_start_frame = '0;
  logic [FIELD_W-1:0] in_end_frame = '0;
  logic in_reverse = 0;
  logic [EPOCH_W-1:0] in_epoch = '0;
  logic [RATE_W-1:0] in_source_rate = '0;
  logic [1:0] in_channel_count = '0;
  logic [FIELD_W-1:0] in_asset_frames = '0;
  logic [ADDR_W-1:0] in_sample_address = '0;
  logic signed [SAMPLE_W-1:0] in_sample_value = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [MIX_W-1:0] out_mix_left_out;
  logic signed [MIX_W-1:0] out_mix_right_out;
  logic out_active;
  logic [FRAME_W-1:0] out_source_frame;
  logic [EPOCH_W-1:0] out_acknowledged_epoch;

  int mismatches;
  int pending;
  bit loaded [STORE_DEPTH];
  int items_sent = 0;
  int burst_left = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int idle_cycles = 0;

  sample_voice_cubic_resampler_core dut (.*);

  sample_voice_cubic_resampler_checker checker_i (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver: stall pattern that periodically changes its character,
  // plus one long hold-off on request.
  initial begin
    int mode;
    int cnt;
    mode = 0;
    cnt = 0;
    forever begin
      @(posedge clk);
      cnt++;
      if (cnt % 150 == 0) mode = $urandom_range(0, 3);
      if (hold_req) begin
        out_stall <= 1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
        out_stall <= 0;
      end else begin
        case (mode)
          0: out_stall <= 0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (cnt % 8 < 3);
        endcase
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic voice_cmd_t rand_cmd(op_t op);
    voice_cmd_t c;
    c.op = op;
    c.ml = $urandom;
    c.mr = $urandom;
    c.sf = $urandom_range(0, 65536);
    c.ef = $urandom_range(0, 65536);
    c.rev = $urandom;
    c.ep = $urandom;
    c.src = $urandom_range(0, 384000);
    c.cc = $urandom_range(0, 3);
    c.af = $urandom_range(0, 65536);
    c.addr = $urandom;
    c.val = $urandom;
    return c;
  endfunction

  // Sends one item in bursts with random gaps; returns once it is taken.
  task automatic issue(voice_cmd_t c);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1;
    in_operation <= c.op;
    in_mix_left_in <= c.ml;
    in_mix_right_in <= c.mr;
    in_start_frame <= c.sf;
    in_end_frame <= c.ef;
    in_reverse <= c.rev;
    in_epoch <= c.ep;
    in_source_rate <= c.src;
    in_channel_count <= c.cc;
    in_asset_frames <= c.af;
    in_sample_address <= c.addr;
    in_sample_value <= c.val;
    do @(posedge clk); while (in_stall);
    if (c.op == OP_LOAD) loaded[c.addr] = 1;
    items_sent++;
    burst_left--;
  endtask

  // Loads every store word that the slice can read and that is still unwritten.
  task automatic fill_slice(int lo, int hi, bit st);
    voice_cmd_t c;
    int idx;
    for (int f = lo; f < hi; f++) begin
      for (int ch = 0; ch < (st ? 2 : 1); ch++) begin
        idx = st ? 2 * f + ch : f;
        if (!loaded[idx]) begin
          c = rand_cmd(OP_LOAD);
          c.addr = idx;
          issue(c);
        end
      end
    end
  endtask

  task automatic do_start(voice_cmd_t c);
    int frames;
    int lo;
    int hi;
    frames = c.af > MAX_FRAMES ? MAX_FRAMES : c.af;
    lo = c.sf < frames ? c.sf : frames;
    hi = c.ef < frames ? c.ef : frames;
    if (hi > lo) fill_slice(lo, hi, c.cc >= 2);
    c.op = OP_START;
    issue(c);
  endtask

  task automatic render(logic signed [MIX_W-1:0] l, logic signed [MIX_W-1:0] r);
    voice_cmd_t c;
    c = rand_cmd(OP_RENDER);
    c.ml = l;
    c.mr = r;
    issue(c);
  endtask

  // Waits until every result has been taken and the block has gone quiet.
  task automatic drain();
    in_valid <= 0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic reg_write(logic [PADDR_W-1:0] a, logic [PDATA_W-1:0] d);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    @(posedge clk);
  endtask

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 22050;
      2: return 44100;
      3: return 48000;
      4: return 96000;
      default: return $urandom_range(1, 384000);
    endcase
  endfunction

  function automatic logic signed [MIX_W-1:0] pick_mix();
    case ($urandom_range(0, 9))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      default: return $urandom;
    endcase
  endfunction

  // One start followed by a run of renders with the odd interruption.
  task automatic play_sequence();
    voice_cmd_t c;
    int n;
    c = rand_cmd(OP_START);
    if ($urandom_range(0, 9) < 7) begin
      c.af = $urandom_range(4, 64);
      c.sf = $urandom_range(0, c.af - 1);
      c.ef = $urandom_range(c.sf + 1, c.af + 4);
    end else begin
      c.af = MAX_FRAMES;
      c.sf = $urandom_range(65470, 65535);
      c.ef = $urandom_range(c.sf + 1, 65536);
    end
    c.src = pick_rate();
    do_start(c);
    n = $urandom_range(5, 40);
    repeat (n) begin
      case ($urandom_range(0, 19))
        0: issue(rand_cmd(OP_LOAD));
        1: issue(rand_cmd(OP_STOP));
        default: render(pick_mix(), pick_mix());
      endcase
    end
  endtask

  task automatic noise_item();
    voice_cmd_t c;
    c = rand_cmd(op_t'($urandom_range(0, 3)));
    if (c.op == OP_START) begin
      if ($urandom_range(0, 1)) c.ef = $urandom_range(0, c.sf);
      else c.ef = (c.sf + $urandom_range(0, 48) > 65536) ? 65536 : c.sf + $urandom_range(0, 48);
      do_start(c);
    end else begin
      issue(c);
    end
  endtask

  task automatic directed_part();
    voice_cmd_t c;
    c = rand_cmd(OP_LOAD);
    c.addr = 0;
    c.val = 16'sh7FFF;
    issue(c);
    c.addr = 1;
    c.val = 16'sh8000;
    issue(c);
    // Mono slice at unity gain with full-scale mix to force saturation.
    c = rand_cmd(OP_START);
    c.af = 16; c.sf = 0; c.ef = 6; c.rev = 0; c.cc = 1; c.src = 0;
    do_start(c);
    render(24'sh7FFFFF, 24'sh800000);
    render(24'sh800000, 24'sh7FFFFF);
    render(0, 0);
    // Stereo reverse slice at the top of the store, played past its start.
    c = rand_cmd(OP_START);
    c.af = MAX_FRAMES; c.sf = 65533; c.ef = 65536; c.rev = 1; c.cc = 3;
    c.src = 384000;
    do_start(c);
    render(pick_mix(), pick_mix());
    render(pick_mix(), pick_mix());
    render(pick_mix(), pick_mix());
    issue(rand_cmd(OP_STOP));
    render(24'sh7FFFFF, 24'sh800000);
    // Empty slice: start not below end.
    c = rand_cmd(OP_START);
    c.af = 65536; c.sf = 65536; c.ef = 0; c.cc = 0;
    do_start(c);
    render(pick_mix(), pick_mix());
    // End beyond the asset length, slow step, mono layout code zero.
    c = rand_cmd(OP_START);
    c.af = 8; c.sf = 2; c.ef = 65536; c.rev = 0; c.cc = 0; c.src = 8000;
    do_start(c);
    render(pick_mix(), pick_mix());
    render(pick_mix(), pick_mix());
    c = rand_cmd(OP_LOAD);
    c.addr = 17'h1FFFF;
    issue(c);
  endtask

  initial begin
    int rates [6];
    int gains [6];
    int target;
    rates = '{8000, 384000, 44100, 0, 96000, 22050};
    gains = '{0, 32768, 16384, 40000, 65535, 1};
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    directed_part();

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      reg_write({REG_OUTPUT_RATE, 2'b00}, rates[ph]);
      reg_write({REG_GAIN, 2'b00}, gains[ph]);
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        if (ph == 2 && !hold_done && items_sent + 100 >= target) begin
          hold_req = 1;
          hold_done = 1;
        end
        if ($urandom_range(0, 3) != 0) play_sequence();
        else noise_item();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
